>>> design/lsh_pkg.sv
// Shared constants and types of the line splitter and hasher.
package lsh_pkg;

    localparam logic [63:0] HASH_SEED   = 64'h0000_0000_00F0_0BA8;
    localparam logic [63:0] HASH_FACTOR = 64'h8BAD_F00D_DEAD_BEEF;
    localparam logic [7:0]  BYTE_CR     = 8'h0D;
    localparam logic [7:0]  BYTE_LF     = 8'h0A;
    localparam logic [31:0] LEN_MAX     = 32'hFFFF_FFFF;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic [47:0] offset;
        logic [31:0] length;
        logic [63:0] hash;
        logic        final_line;
    } t_line;

endpackage

>>> design/lsh_hash_step.sv
// One multiply-xor hash step: hash * factor mod 2^64, xor sign-extended byte.
module lsh_hash_step (
    input  logic [63:0] i_hash,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_hash
);

    localparam logic [31:0] K_LO = lsh_pkg::HASH_FACTOR[31:0];
    localparam logic [31:0] K_HI = lsh_pkg::HASH_FACTOR[63:32];

    logic [63:0] p_ll;
    logic [31:0] p_hl;
    logic [31:0] p_lh;
    logic [31:0] cross_sum;
    logic [63:0] product;
    logic [63:0] ext;

    // Only the low 64 bits of the product matter: high x high drops out.
    assign p_ll      = {32'd0, i_hash[31:0]} * {32'd0, K_LO};
    assign p_hl      = i_hash[63:32] * K_LO;
    assign p_lh      = i_hash[31:0] * K_HI;
    assign cross_sum = p_hl + p_lh;
    assign product   = p_ll + {cross_sum, 32'd0};
    assign ext       = {{56{i_byte[7]}}, i_byte};
    assign o_hash    = product ^ ext;

endmodule

>>> design/lsh_line_tracker.sv
// Open-line state, line end detection and the emitted line record.
module lsh_line_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_command,
    input  logic [7:0]           i_data_byte,
    output logic                 o_produce,
    output lsh_pkg::t_line       o_line
);

    logic [63:0] r_hash;
    logic [31:0] r_len;
    logic [47:0] r_start;
    logic [47:0] r_pos;
    logic        r_cr;

    logic [63:0] n_hash;
    logic [31:0] n_len;
    logic [47:0] n_start;
    logic [47:0] n_pos;
    logic        n_cr;

    logic        is_end;
    logic        is_lf;
    logic        is_cr;
    logic        cut_before;
    logic [63:0] base_hash;
    logic [31:0] base_len;
    logic [47:0] base_start;
    logic [63:0] step_hash;
    logic [31:0] step_len;
    logic [47:0] pos_inc;

    assign is_end     = (i_command == lsh_pkg::CMD_END);
    assign is_lf      = (i_data_byte == lsh_pkg::BYTE_LF);
    assign is_cr      = (i_data_byte == lsh_pkg::BYTE_CR);
    // A byte other than LF after a CR closes the line before that byte.
    assign cut_before = r_cr && !is_lf;

    assign base_hash  = cut_before ? lsh_pkg::HASH_SEED : r_hash;
    assign base_len   = cut_before ? 32'd0 : r_len;
    assign base_start = cut_before ? r_pos : r_start;

    lsh_hash_step u_hash_step (
        .i_hash (base_hash),
        .i_byte (i_data_byte),
        .o_hash (step_hash)
    );

    assign step_len = (base_len == lsh_pkg::LEN_MAX) ? lsh_pkg::LEN_MAX : base_len + 32'd1;
    assign pos_inc  = r_pos + 48'd1;

    assign o_produce = is_end || is_lf || cut_before;

    always_comb begin
        o_line = '0;
        priority if (is_end) begin
            o_line.offset     = r_start;
            o_line.length     = r_len;
            o_line.hash       = r_hash;
            o_line.final_line = 1'b1;
        end else if (cut_before) begin
            o_line.offset     = r_start;
            o_line.length     = r_len;
            o_line.hash       = r_hash;
            o_line.final_line = 1'b0;
        end else begin
            o_line.offset     = base_start;
            o_line.length     = step_len;
            o_line.hash       = step_hash;
            o_line.final_line = 1'b0;
        end
    end

    always_comb begin
        priority if (is_end) begin
            n_hash  = lsh_pkg::HASH_SEED;
            n_len   = 32'd0;
            n_start = 48'd0;
            n_pos   = 48'd0;
            n_cr    = 1'b0;
        end else if (is_lf) begin
            // LF closes the line after itself; open a new one at the next byte
            n_hash  = lsh_pkg::HASH_SEED;
            n_len   = 32'd0;
            n_start = pos_inc;
            n_pos   = pos_inc;
            n_cr    = 1'b0;
        end else begin
            n_hash  = step_hash;
            n_len   = step_len;
            n_start = base_start;
            n_pos   = pos_inc;
            n_cr    = is_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= lsh_pkg::HASH_SEED;
            r_len   <= 32'd0;
            r_start <= 48'd0;
            r_pos   <= 48'd0;
            r_cr    <= 1'b0;
        end else if (i_advance) begin
            r_hash  <= n_hash;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_cr    <= n_cr;
        end
    end

endmodule

>>> design/line_splitter_hasher.sv
// A closing transaction passes the input register, then the tracker, and its line is
// stored in the output register; the line of a lone CR closes only when the next transaction arrives.
// Throughput: one transaction per cycle while no closed line waits on a stalled output,
// set by the combinational multiply-xor recurrence of the open line's hash in lsh_hash_step.
// Bytes that close no line keep flowing while a finished line waits at the output.
// Reset (i_rst_n low, synchronous) empties both registers, clears the stream
// position and opens an empty line with the seed hash.
module line_splitter_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_line_offset,
    output logic [31:0] o_line_length,
    output logic [63:0] o_line_hash,
    output logic        o_final_line
);

    logic           r_in_valid;
    logic           r_command;
    logic [7:0]     r_data_byte;
    logic           r_out_valid;
    lsh_pkg::t_line r_line;

    logic           produce;
    logic           out_free;
    logic           advance;
    lsh_pkg::t_line line;

    lsh_line_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_command   (r_command),
        .i_data_byte (r_data_byte),
        .o_produce   (produce),
        .o_line      (line)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // Bytes that close no line pass even while the output stalls.
    assign advance    = r_in_valid && (!produce || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command   <= i_command;
            r_data_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_line <= line;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_offset = r_line.offset;
    assign o_line_length = r_line.length;
    assign o_line_hash   = r_line.hash;
    assign o_final_line  = r_line.final_line;

endmodule

>>> design/lsh_checker.sv
// Port-level checks of the line splitter and hasher, bound to the top level.
module lsh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] o_line_offset,
    input  logic [31:0] o_line_length,
    input  logic [63:0] o_line_hash,
    input  logic        o_final_line
);

    // Hold a stalled result transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_offset)
            && $stable(o_line_length) && $stable(o_line_hash) && $stable(o_final_line))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A line closed by LF or CR holds at least its terminator.
    a_nonfinal_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_line |-> o_line_length != 32'd0)
        else $error("empty line without end of input");

    a_empty_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_length == 32'd0 |-> o_line_hash == lsh_pkg::HASH_SEED)
        else $error("empty line hash differs from seed");

endmodule

bind line_splitter_hasher lsh_checker u_lsh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_line_offset (o_line_offset),
    .o_line_length (o_line_length),
    .o_line_hash   (o_line_hash),
    .o_final_line  (o_final_line)
);

>>> verif/tb_line_splitter_hasher.sv
// Self-checking testbench for the line splitter and hasher: directed table, random text.
`timescale 1ns / 1ps

module tb_line_splitter_hasher;

    typedef struct packed {
        logic           cmd;
        logic [7:0]     data;
        logic           typed;
        lsh_pkg::t_line want;
    } t_stim_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_CLOGGED
    } t_rx_mode;

    localparam lsh_pkg::t_line NO_LINE = '0;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM = 700;
    localparam int MAX_REPORTS = 10;

    // Typed rows are empty final lines taken from the table; the line predictor gives all other rows.
    localparam t_stim_row DIRECTED[N_DIRECTED] = '{
        {lsh_pkg::CMD_END,  8'h00, 1'b1, 48'd0, 32'd0, lsh_pkg::HASH_SEED, 1'b1},
        {lsh_pkg::CMD_END,  8'hFF, 1'b1, 48'd0, 32'd0, lsh_pkg::HASH_SEED, 1'b1},
        {lsh_pkg::CMD_DATA, 8'h00, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'hFF, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h80, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h7F, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0A, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0A, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h41, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_END,  8'h00, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h55, 1'b0, NO_LINE},
        {lsh_pkg::CMD_END,  8'hAA, 1'b0, NO_LINE},
        {lsh_pkg::CMD_END,  8'h00, 1'b1, 48'd0, 32'd0, lsh_pkg::HASH_SEED, 1'b1},
        {lsh_pkg::CMD_DATA, 8'h0A, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0A, 1'b0, NO_LINE},
        {lsh_pkg::CMD_END,  8'h5A, 1'b1, 48'd2, 32'd0, lsh_pkg::HASH_SEED, 1'b1},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0A, 1'b0, NO_LINE},
        {lsh_pkg::CMD_DATA, 8'h0D, 1'b0, NO_LINE},
        {lsh_pkg::CMD_END,  8'h00, 1'b0, NO_LINE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = lsh_pkg::CMD_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [47:0] o_line_offset;
    logic [31:0] o_line_length;
    logic [63:0] o_line_hash;
    logic        o_final_line;

    // Predictor state: the open line, the stream position and a pending CR.
    lsh_pkg::t_line open_ln = {48'd0, 32'd0, lsh_pkg::HASH_SEED, 1'b0};
    logic [47:0]    byte_pos = '0;
    logic           cr_seen = 1'b0;
    lsh_pkg::t_line pending_lines[$];
    lsh_pkg::t_line exp_ln;
    int             n_mismatch = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;

    line_splitter_hasher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_offset (o_line_offset),
        .o_line_length (o_line_length),
        .o_line_hash   (o_line_hash),
        .o_final_line  (o_final_line)
    );

    always #1 i_clk = ~i_clk;

    task automatic start_line();
        open_ln.offset     = byte_pos;
        open_ln.length     = '0;
        open_ln.hash       = lsh_pkg::HASH_SEED;
        open_ln.final_line = 1'b0;
    endtask

    // Advance the predicted splitter by one transaction; got is set when a line closes.
    task automatic advance_lines(input logic cmd, input logic [7:0] b,
                                 output bit got, output lsh_pkg::t_line ln);
        got = 1'b0;
        ln  = open_ln;
        if (cmd == lsh_pkg::CMD_END) begin
            got           = 1'b1;
            ln.final_line = 1'b1;
            byte_pos      = '0;
            cr_seen       = 1'b0;
            start_line();
            return;
        end
        // A CR closes its line only once the next byte turns out not to be LF.
        if (cr_seen) begin
            cr_seen = 1'b0;
            if (b != lsh_pkg::BYTE_LF) begin
                got = 1'b1;
                ln  = open_ln;
                start_line();
            end
        end
        open_ln.hash = (open_ln.hash * lsh_pkg::HASH_FACTOR) ^ {{56{b[7]}}, b};
        if (open_ln.length != lsh_pkg::LEN_MAX)
            open_ln.length = open_ln.length + 32'd1;
        byte_pos = byte_pos + 48'd1;
        if (b == lsh_pkg::BYTE_CR) begin
            cr_seen = 1'b1;
        end else if (b == lsh_pkg::BYTE_LF) begin
            got = 1'b1;
            ln  = open_ln;
            start_line();
        end
    endtask

    // Drive one transaction and hold it until accepted, then record its line if any.
    task automatic send_item(input logic cmd, input logic [7:0] b,
                             input logic typed, input lsh_pkg::t_line want);
        bit             got;
        lsh_pkg::t_line ln;
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        advance_lines(cmd, b, got, ln);
        if (typed)
            pending_lines.insert(pending_lines.size(), want);
        else if (got)
            pending_lines.insert(pending_lines.size(), ln);
    endtask

    task automatic hold_off(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_lines.size() != 0);
    endtask

    // Receiver: switch between open, choppy and clogged stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_mode     <= RX_OPEN;
            rx_left     <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 2));
                rx_left <= $urandom_range(20, 150);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:    i_out_ready <= 1'b1;
                RX_CHOPPY:  i_out_ready <= 1'($urandom_range(0, 1));
                default:    i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_lines.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("mismatch #%0d: unexpected line off=%0h len=%0h hash=%h fin=%0b",
                             n_mismatch, o_line_offset, o_line_length, o_line_hash,
                             o_final_line);
            end else begin
                exp_ln = pending_lines.pop_front();
                if (o_line_offset !== exp_ln.offset || o_line_length !== exp_ln.length ||
                    o_line_hash !== exp_ln.hash || o_final_line !== exp_ln.final_line) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("mismatch #%0d: off exp=%0h got=%0h len exp=%0h got=%0h",
                                 n_mismatch, exp_ln.offset, o_line_offset,
                                 exp_ln.length, o_line_length);
                        $display("    hash exp=%h got=%h fin exp=%0b got=%0b",
                                 exp_ln.hash, o_line_hash, exp_ln.final_line, o_final_line);
                    end
                end
            end
        end
    end

    initial begin
        int   pick;
        int   burst_left;
        bit   lf_next;
        logic cmd;
        logic [7:0] b;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++)
            send_item(DIRECTED[k].cmd, DIRECTED[k].data, DIRECTED[k].typed, DIRECTED[k].want);
        wait_drained();

        // Mostly text with CR, LF and CRLF endings, some raw bytes and end-of-input marks.
        burst_left = $urandom_range(1, 40);
        lf_next = 1'b0;
        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            cmd  = lsh_pkg::CMD_DATA;
            b    = 8'($urandom_range(8'h20, 8'h7E));
            if (lf_next) begin
                b       = lsh_pkg::BYTE_LF;
                lf_next = 1'b0;
            end else if (pick < 3) begin
                cmd = lsh_pkg::CMD_END;
                b   = 8'($urandom_range(0, 255));
            end else if (pick < 12) begin
                b = lsh_pkg::BYTE_LF;
            end else if (pick < 20) begin
                b       = lsh_pkg::BYTE_CR;
                lf_next = 1'($urandom_range(0, 1));
            end else if (pick < 30) begin
                b = 8'($urandom_range(0, 255));
            end
            send_item(cmd, b, 1'b0, NO_LINE);
            if (k == N_RANDOM / 2) begin
                wait_drained();
            end else if (--burst_left == 0) begin
                hold_off($urandom_range(1, 8));
                burst_left = $urandom_range(1, 60);
            end
        end
        send_item(lsh_pkg::CMD_END, 8'($urandom_range(0, 255)), 1'b0, NO_LINE);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #400_000;
        $display("tb: failure");
        $finish;
    end

endmodule
